// File: rtl/sus_pkg.sv
// ----------------------------------------------------------------------------
// sus_pkg - shared definitions for the sorted unique set
// Field widths, request and status codes, and the cell control struct.
// ----------------------------------------------------------------------------
package sus_pkg;

    localparam int CAPACITY_DEF = 256;

    localparam int KIND_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 8;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 9;
    localparam int COUNT_W  = 9;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd4;

    typedef struct packed {
        logic eval;   // capture compare flags and read tap
        logic shift;  // apply an insert across the row
    } t_cell_ctl;

endpackage

// File: rtl/sus_cell.sv
// ----------------------------------------------------------------------------
// sus_cell - one storage cell of the sorted set
// Holds one entry, compares it with the request value and takes the insert
// value or its left neighbour's entry when an insert shifts the row up.
// ----------------------------------------------------------------------------
module sus_cell (
    input  logic                         i_clk,
    input  sus_pkg::t_cell_ctl           i_ctl,
    input  logic [sus_pkg::VALUE_W-1:0]  i_value,
    input  logic                         i_valid,
    input  logic                         i_sel,
    input  logic [sus_pkg::VALUE_W-1:0]  i_left_entry,
    input  logic                         i_left_lt,
    output logic [sus_pkg::VALUE_W-1:0]  o_entry,
    output logic                         o_lt,
    output logic                         o_eq,
    output logic [sus_pkg::VALUE_W-1:0]  o_rd
);

    logic [sus_pkg::VALUE_W-1:0] r_entry;
    logic                        r_lt;
    logic                        r_eq;
    logic [sus_pkg::VALUE_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.eval) begin
            r_lt <= i_valid && (r_entry < i_value);
            r_eq <= i_valid && (r_entry == i_value);
            r_rd <= i_sel ? r_entry : '0;
        end
        // keep smaller entries, otherwise take the new value or move up
        if (i_ctl.shift && !r_lt) begin
            r_entry <= i_left_lt ? i_value : i_left_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;
    assign o_rd    = r_rd;

endmodule

// File: rtl/sorted_unique_set_insert_core.sv
// ----------------------------------------------------------------------------
// sorted_unique_set_insert_core - sorted set of distinct 32-bit numbers
// Sequence: an accepted request is compared in the eval state, applied in the
// apply state, and o_done then pulses with the registered result. Busy is high
// in eval and apply, so a new request is taken only after the apply state.
// Reset (synchronous, active low) empties the set and idles the sequencer;
// cell contents are not cleared. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module sorted_unique_set_insert_core #(
    parameter int CAPACITY = sus_pkg::CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sus_pkg::KIND_W-1:0]    i_kind,
    input  logic [sus_pkg::VALUE_W-1:0]   i_value,
    input  logic [sus_pkg::INDEX_W-1:0]   i_index,
    output logic                          o_done,
    output logic [sus_pkg::STATUS_W-1:0]  o_status,
    output logic [sus_pkg::POS_W-1:0]     o_position,
    output logic [sus_pkg::COUNT_W-1:0]   o_count,
    output logic [sus_pkg::VALUE_W-1:0]   o_read_value
);

    // wide enough to hold CAPACITY itself
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EVAL  = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    t_state                        r_state, n_state;
    logic [CW-1:0]                 r_count, n_count;
    logic [sus_pkg::KIND_W-1:0]    r_kind;
    logic [sus_pkg::VALUE_W-1:0]   r_value;
    logic [sus_pkg::INDEX_W-1:0]   r_index;

    logic                          r_done;
    logic [sus_pkg::STATUS_W-1:0]  r_status, n_status;
    logic [sus_pkg::POS_W-1:0]     r_position, n_position;
    logic [sus_pkg::COUNT_W-1:0]   r_out_count, n_out_count;
    logic [sus_pkg::VALUE_W-1:0]   r_read_value, n_read_value;

    sus_pkg::t_cell_ctl            w_ctl;
    logic [sus_pkg::VALUE_W-1:0]   w_entry [CAPACITY];
    logic [sus_pkg::VALUE_W-1:0]   w_rd    [CAPACITY];
    logic [CAPACITY-1:0]           w_lt;
    logic [CAPACITY-1:0]           w_eq;

    logic [CW-1:0]                 w_pos;
    logic [sus_pkg::VALUE_W-1:0]   w_rd_all;
    logic                          w_dup;
    logic                          w_full;
    logic                          w_rd_ok;
    logic                          w_accept;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    assign w_dup   = |w_eq;
    assign w_full  = (r_count == CW'(CAPACITY));
    assign w_rd_ok = ({{CW{1'b0}}, r_index} < {{sus_pkg::INDEX_W{1'b0}}, r_count});

    // Shift the row only for a fresh insert into a set with room
    assign w_ctl.eval  = (r_state == S_EVAL);
    assign w_ctl.shift = (r_state == S_APPLY) && (r_kind == sus_pkg::KIND_INSERT)
                         && !w_dup && !w_full;

    // ---- cell row ----------------------------------------------------------
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [sus_pkg::VALUE_W-1:0] w_left_entry;
        logic                        w_left_lt;
        logic                        w_valid;
        logic                        w_sel;

        if (g == 0) begin : g_head
            // nothing sits left of the first cell: it always takes the value
            assign w_left_entry = '0;
            assign w_left_lt    = 1'b1;
        end else begin : g_body
            assign w_left_entry = w_entry[g-1];
            assign w_left_lt    = w_lt[g-1];
        end

        assign w_valid = (CW'(g) < r_count);
        assign w_sel   = ({{CW{1'b0}}, r_index} == (CW + sus_pkg::INDEX_W)'(g));

        sus_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_value      (r_value),
            .i_valid      (w_valid),
            .i_sel        (w_sel),
            .i_left_entry (w_left_entry),
            .i_left_lt    (w_left_lt),
            .o_entry      (w_entry[g]),
            .o_lt         (w_lt[g]),
            .o_eq         (w_eq[g]),
            .o_rd         (w_rd[g])
        );
    end

    // ---- position and read data from the registered cell flags -------------
    // The less-than flags form a prefix of ones; encode the edge to a place.
    always_comb begin
        w_pos    = w_lt[CAPACITY-1] ? CW'(CAPACITY) : '0;
        w_rd_all = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (!w_lt[i] && ((i == 0) || w_lt[(i == 0) ? 0 : i-1])) begin
                w_pos = w_pos | CW'(i);
            end
            w_rd_all = w_rd_all | w_rd[i];
        end
    end

    // ---- sequencer and result ---------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_status     = r_status;
        n_position   = r_position;
        n_out_count  = r_out_count;
        n_read_value = r_read_value;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                n_state      = S_IDLE;
                n_read_value = '0;
                case (r_kind)
                    sus_pkg::KIND_INSERT: begin
                        n_position = sus_pkg::POS_W'(w_pos);
                        if (w_dup) begin
                            n_status = sus_pkg::ST_PRESENT;
                        end else if (w_full) begin
                            n_status = sus_pkg::ST_FULL;
                        end else begin
                            n_status = sus_pkg::ST_INSERTED;
                            n_count  = r_count + CW'(1);
                        end
                    end
                    sus_pkg::KIND_READ: begin
                        n_position = sus_pkg::POS_W'(r_index);
                        if (w_rd_ok) begin
                            n_status     = sus_pkg::ST_OK;
                            n_read_value = w_rd_all;
                        end else begin
                            n_status = sus_pkg::ST_RANGE;
                        end
                    end
                    sus_pkg::KIND_CLEAR: begin
                        // drop the count; leave the cells as they are
                        n_status   = sus_pkg::ST_OK;
                        n_position = '0;
                        n_count    = '0;
                    end
                    default: begin
                        n_status   = sus_pkg::ST_OK;
                        n_position = '0;
                    end
                endcase
                n_out_count = sus_pkg::COUNT_W'(n_count);
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= (r_state == S_APPLY);
        end
    end

    // Hold the request and the result registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind  <= i_kind;
            r_value <= i_value;
            r_index <= i_index;
        end
        r_status     <= n_status;
        r_position   <= n_position;
        r_out_count  <= n_out_count;
        r_read_value <= n_read_value;
    end

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_position   = r_position;
    assign o_count      = r_out_count;
    assign o_read_value = r_read_value;

endmodule
